// ----- rtl/core/mfd_pkg.sv -----
// Package for the face dissipation block: sequencer states, widths, the
// divider request and a helper function for saturation. No dependencies.
`timescale 1ns / 1ps
package mfd_pkg;
  localparam int unsigned EpsW = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_LAM,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction
endpackage

// ----- rtl/core/mfd_if.sv -----
// Valid/ready stream interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface mfd_if #(parameter int unsigned W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/mfd_div.sv -----
// Restoring bit-serial divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on mfd_pkg.
`timescale 1ns / 1ps
module mfd_div (
  input  logic clk,
  input  logic rst,
  input  mfd_pkg::div_req_t req,
  output logic busy,
  output logic [63:0] quot
);
  import mfd_pkg::*;
  logic [6:0] cnt;
  logic [32:0] rem;
  logic [63:0] q;
  logic [31:0] den;
  logic [32:0] trial;
  logic [32:0] sh;
  assign sh = {rem[31:0], q[63]};
  assign trial = sh - {1'b0, den};
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= 7'd64;
      rem <= '0;
      q <= req.num;
      den <= req.den;
    end else if (cnt != 0) begin
      cnt <= cnt - 7'd1;
      if (!trial[32]) begin
        rem <= trial;
        q <= {q[62:0], 1'b1};
      end else begin
        rem <= sh;
        q <= {q[62:0], 1'b0};
      end
    end
  end
  assign busy = (cnt != 0);
  assign quot = q;
endmodule

// ----- rtl/core/movers_face_dissipation.sv -----
// Top level of the face dissipation block: sequencer, one shared
// multiplier and the shared divider. Depends on mfd_pkg, mfd_if, mfd_div.
`timescale 1ns / 1ps
// channel  dir  payload
// in       in   row_start, density..total_energy (189 bits)
// out      out  mass, momentum, energy dissipation (96 bits)
// cfg      in   epsilon_lsb (16 bits)
// While a face is worked on, the block takes no new cell. A cell that
// opens a row, or the first cell after reset, is only stored. A face
// runs nine multiplies on the shared multiplier, a step for the
// wave-speed bounds and three divisions on the bit-serial divider
// (start, 64 quotient bits, collect). A component with a difference under
// epsilon skips its division.
// Reset clears the sequencer, have_previous, the output flag and epsilon (to 1).
// A finished result holds in the output register while the next cell is
// taken; the next face waits before its output step until that result leaves.
module movers_face_dissipation #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  mfd_if.sink in,
  mfd_if.source out,
  mfd_if.sink cfg
);
  import mfd_pkg::*;
  typedef logic signed [31:0] q_t;

  state_t state, state_next;
  logic [15:0] eps;
  logic have_prev;
  logic out_full;
  q_t rL, uL, cL, pL, mL, eL, rR, uR, cR, pR, mR, eR;
  q_t f1L, f1R, f2L, f2R, f3L, f3R, lmax, lmin, a1, a2, a3;
  q_t o1, o2, o3;
  logic [1:0] sub;
  logic dstarted;
  div_req_t dreq;
  logic dbusy;
  logic [63:0] dq;

  // shared multiplier operands
  q_t ma, mb;
  logic [4:0] sh;
  logic signed [63:0] prod, pshift;
  assign prod = ma * mb;
  assign pshift = prod >>> sh;

  logic take;
  assign in.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign take = in.valid && in.ready;

  mfd_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quot(dq));

  function automatic q_t qabs(input q_t x);
    return sat64(x[31] ? -64'(x) : 64'(x));
  endfunction
  function automatic q_t sdiff(input q_t a, input q_t b);
    return sat64(64'(a) - 64'(b));
  endfunction
  // unsaturated magnitude: the most negative value gives 2^31
  function automatic logic [31:0] uabs(input q_t x);
    return x[31] ? 32'(~x) + 32'd1 : 32'(x);
  endfunction

  // alpha operands of the current component
  q_t df, du;
  always_comb begin
    case (state)
      ST_A1: begin df = sdiff(f1R, f1L); du = sdiff(rR, rL); end
      ST_A2: begin df = sdiff(f2R, f2L); du = sdiff(f1R, f1L); end
      default: begin df = sdiff(f3R, f3L); du = sdiff(eR, eL); end
    endcase
  end
  logic [31:0] adf, adu;
  q_t qa, alpha;
  logic [63:0] qsat;
  assign adf = uabs(df);
  assign adu = uabs(du);
  assign qsat = (du == 0 || dq > 64'h7fffffff) ? 64'h7fffffff : dq;
  always_comb begin
    qa = q_t'(qsat[31:0]);
    if ({16'd0, eps} > 32'(adu)) alpha = lmin;
    else if ({16'd0, eps} > 32'(adf)) alpha = '0;
    else if (qa > lmax) alpha = lmax;
    else if (qa < lmin) alpha = lmin;
    else alpha = qa;
  end
  logic fast;
  assign fast = ({16'd0, eps} > 32'(adu)) || ({16'd0, eps} > 32'(adf));

  // lambda bounds from both cells
  function automatic q_t mx(input q_t a, input q_t b);
    return a > b ? a : b;
  endfunction
  function automatic q_t mn(input q_t a, input q_t b);
    return a < b ? a : b;
  endfunction
  q_t s0, s1, s2, s3, s4, s5;
  assign s0 = sat64(64'(uL) - 64'(cL) < 0 ? 64'(cL) - 64'(uL) : 64'(uL) - 64'(cL));
  assign s1 = sat64(64'(uL) + 64'(cL) < 0 ? -(64'(uL) + 64'(cL)) : 64'(uL) + 64'(cL));
  assign s2 = qabs(uL);
  assign s3 = sat64(64'(uR) - 64'(cR) < 0 ? 64'(cR) - 64'(uR) : 64'(uR) - 64'(cR));
  assign s4 = sat64(64'(uR) + 64'(cR) < 0 ? -(64'(uR) + 64'(cR)) : 64'(uR) + 64'(cR));
  assign s5 = qabs(uR);

  // multiplier operand select: in the flux states sub picks left or right cell, in the output state the component
  always_comb begin
    ma = '0; mb = '0; sh = 5'(FRAC_BITS);
    case (state)
      ST_F1: begin ma = sub[0] ? rR : rL; mb = sub[0] ? uR : uL; end
      ST_F2: begin ma = sub[0] ? f1R : f1L; mb = sub[0] ? uR : uL; end
      ST_F3: begin
        ma = sub[0] ? sdiff(eR, -pR) : sdiff(eL, -pL);
        mb = sub[0] ? uR : uL;
      end
      ST_OUT: begin
        sh = 5'(FRAC_BITS + 1);
        case (sub)
          2'd0: begin ma = a1; mb = sdiff(rR, rL); end
          2'd1: begin ma = a2; mb = sdiff(mR, mL); end
          default: begin ma = a3; mb = sdiff(eR, eL); end
        endcase
      end
      default: ;
    endcase
  end

  // sequencer next state: hold the last alpha step until the output register is free
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take) state_next = (in.data[0] || !have_prev) ? ST_IDLE : ST_F1;
      ST_F1: if (sub[0]) state_next = ST_F2;
      ST_F2: if (sub[0]) state_next = ST_F3;
      ST_F3: if (sub[0]) state_next = ST_LAM;
      ST_LAM: state_next = ST_A1;
      ST_A1: if (fast || (dstarted && !dbusy)) state_next = ST_A2;
      ST_A2: if (fast || (dstarted && !dbusy)) state_next = ST_A3;
      ST_A3: if ((fast || (dstarted && !dbusy)) && !out_full) state_next = ST_OUT;
      ST_OUT: if (sub == 2'd2) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.num = {32'd0, adf} << FRAC_BITS;
    dreq.den = adu;
    if ((state == ST_A1 || state == ST_A2 || state == ST_A3) && !fast && !dstarted)
      dreq.start = 1'b1;
  end

  assign out.valid = out_full;
  assign out.data = {o3, o2, o1};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      eps <= 16'd1;
      have_prev <= 1'b0;
      out_full <= 1'b0;
      sub <= '0;
      dstarted <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) eps <= cfg.data[15:0];
      // raise the output flag as the last product lands, drop it on accept
      if (state == ST_OUT && state_next == ST_IDLE) out_full <= 1'b1;
      else if (out.valid && out.ready) out_full <= 1'b0;
      // advance sub-step within a multiply phase
      if (state != state_next) sub <= '0;
      else if (state == ST_F1 || state == ST_F2 || state == ST_F3 || state == ST_OUT)
        sub <= sub + 2'd1;
      if (dreq.start) dstarted <= 1'b1;
      else if (state != state_next) dstarted <= 1'b0;
      if (take) begin
        have_prev <= 1'b1;
        rL <= rR; uL <= uR; cL <= cR; pL <= pR; mL <= mR; eL <= eR;
        rR <= {1'b0, in.data[31:1]};
        uR <= in.data[63:32];
        cR <= {1'b0, in.data[94:64]};
        pR <= {1'b0, in.data[125:95]};
        mR <= in.data[157:126];
        eR <= {1'b0, in.data[188:158]};
      end
      case (state)
        ST_F1: if (sub[0]) f1R <= sat64(pshift); else f1L <= sat64(pshift);
        ST_F2:
          if (sub[0]) f2R <= sat64(64'(sat64(pshift)) + 64'(pR));
          else f2L <= sat64(64'(sat64(pshift)) + 64'(pL));
        ST_F3: if (sub[0]) f3R <= sat64(pshift); else f3L <= sat64(pshift);
        ST_LAM: begin
          lmax <= mx(mx(mx(s0, s1), s2), mx(mx(s3, s4), s5));
          lmin <= mx(mn(mn(s0, s1), s2), mn(mn(s3, s4), s5));
        end
        ST_A1: if (state_next != state) a1 <= alpha;
        ST_A2: if (state_next != state) a2 <= alpha;
        ST_A3: if (state_next != state) a3 <= alpha;
        ST_OUT:
          case (sub)
            2'd0: o1 <= sat64(pshift);
            2'd1: o2 <= sat64(pshift);
            default: o3 <= sat64(pshift);
          endcase
        default: ;
      endcase
    end
  end
endmodule

// ----- verif/movers_face_dissipation_test.sv -----
// Self-checking bench for movers_face_dissipation: drives cells, predicts faces.
// Depends on mfd_pkg, mfd_if and the block itself.
`timescale 1ns / 1ps
module movers_face_dissipation_test;
  import mfd_pkg::*;

  localparam int unsigned Frac = 16;
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned LongHold = 600;

  typedef struct packed {
    logic [30:0] total_energy;
    logic signed [31:0] momentum;
    logic [30:0] pressure;
    logic [30:0] sound_speed;
    logic signed [31:0] velocity;
    logic [30:0] density;
    logic        row_start;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] energy;
    logic signed [31:0] mom;
    logic signed [31:0] mass;
  } face_t;

  logic clk = 0;
  logic rst = 1;

  mfd_if #(.W(189)) in_ch ();
  mfd_if #(.W(96))  out_ch ();
  mfd_if #(.W(EpsW)) cfg_ch ();

  movers_face_dissipation #(.FRAC_BITS(Frac)) dut (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Pending cells, expected faces and the predictor's own copy of the state.
  cell_t pending_cells[$];
  face_t expected_faces[$];
  logic [EpsW-1:0] eps_writes[$];
  int errors = 0;
  int unsigned eps_now = 1;
  cell_t left_cell;
  bit have_left = 0;
  int unsigned cell_gap = 0;
  bit burst_mode = 0;
  int stall_asked = 0;
  int stall_served = 0;
  int unsigned out_wait = 0;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  // Product floored by the fraction width (>>> on signed is floor).
  function automatic longint fx_mul(longint a, longint b, int unsigned sh);
    longint p;
    p = a * b;
    return sat32(p >>> sh);
  endfunction

  function automatic longint wave_speed(longint df, longint du, longint lmin, longint lmax,
                                        int unsigned eps);
    longint q;
    if (mag(du) < eps) return lmin;
    if (mag(df) < eps) return 0;
    if (du == 0) q = 64'sd2147483647;
    else begin
      q = (mag(df) << Frac) / mag(du);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
    end
    if (q > lmax) return lmax;
    if (q < lmin) return lmin;
    return q;
  endfunction

  function automatic face_t predict_face(cell_t l, cell_t r, int unsigned eps);
    longint rl, ul, cl, pl, ml, el, rr, ur, cr, pr, mr, er;
    longint f1l, f1r, f2l, f2r, f3l, f3r, lmax, lmin, xl, xr, nl, nr;
    longint s[6];
    longint a1, a2, a3;
    face_t f;
    rl = l.density; ul = l.velocity; cl = l.sound_speed; pl = l.pressure;
    ml = l.momentum; el = l.total_energy;
    rr = r.density; ur = r.velocity; cr = r.sound_speed; pr = r.pressure;
    mr = r.momentum; er = r.total_energy;
    f1l = fx_mul(rl, ul, Frac);
    f1r = fx_mul(rr, ur, Frac);
    f2l = sat32(fx_mul(f1l, ul, Frac) + pl);
    f2r = sat32(fx_mul(f1r, ur, Frac) + pr);
    f3l = fx_mul(sat32(el + pl), ul, Frac);
    f3r = fx_mul(sat32(er + pr), ur, Frac);
    s[0] = sat32(mag(ul - cl)); s[1] = sat32(mag(ul + cl)); s[2] = sat32(mag(ul));
    s[3] = sat32(mag(ur - cr)); s[4] = sat32(mag(ur + cr)); s[5] = sat32(mag(ur));
    xl = s[0]; nl = s[0]; xr = s[3]; nr = s[3];
    for (int i = 1; i < 3; i++) begin
      if (s[i] > xl) xl = s[i];
      if (s[i] < nl) nl = s[i];
      if (s[i+3] > xr) xr = s[i+3];
      if (s[i+3] < nr) nr = s[i+3];
    end
    lmax = xl > xr ? xl : xr;
    lmin = nl > nr ? nl : nr;
    a1 = wave_speed(sat32(f1r - f1l), sat32(rr - rl), lmin, lmax, eps);
    a2 = wave_speed(sat32(f2r - f2l), sat32(f1r - f1l), lmin, lmax, eps);
    a3 = wave_speed(sat32(f3r - f3l), sat32(er - el), lmin, lmax, eps);
    f.mass = fx_mul(a1, sat32(rr - rl), Frac + 1);
    f.mom = fx_mul(a2, sat32(mr - ml), Frac + 1);
    f.energy = fx_mul(a3, sat32(er - el), Frac + 1);
    return f;
  endfunction

  // Mostly physical magnitudes (a few units in Q16.16), sometimes full range.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(0, 8 << Frac);
    endcase
  endfunction

  function automatic cell_t random_cell(bit first);
    cell_t c;
    logic [31:0] v;
    c.row_start = first;
    c.density = 31'(pick_word());
    v = pick_word();
    c.velocity = $urandom_range(0, 1) ? -$signed(v) : $signed(v);
    c.sound_speed = 31'(pick_word());
    c.pressure = 31'(pick_word());
    v = pick_word();
    c.momentum = $urandom_range(0, 1) ? -$signed(v) : $signed(v);
    c.total_energy = 31'(pick_word());
    // Sometimes repeat the energy and (nearly) the density of the last queued cell to hit tiny differences.
    if (pending_cells.size() > 0 && $urandom_range(0, 5) == 0) begin
      c.density = pending_cells[$].density + 31'($urandom_range(0, 2));
      c.total_energy = pending_cells[$].total_energy;
    end
    return c;
  endfunction

  function automatic cell_t make_cell(bit first, logic [30:0] rho, logic signed [31:0] u,
                                      logic [30:0] c, logic [30:0] p,
                                      logic signed [31:0] m, logic [30:0] e);
    cell_t x;
    x.row_start = first; x.density = rho; x.velocity = u; x.sound_speed = c;
    x.pressure = p; x.momentum = m; x.total_energy = e;
    return x;
  endfunction

  // Queue rows: a row start followed by a run of faces with random content,
  // with an occasional stray row start to break a row early.
  task automatic queue_rows(int unsigned n);
    int unsigned left;
    int unsigned row_len;
    left = n;
    while (left > 0) begin
      row_len = $urandom_range(2, 24);
      for (int unsigned i = 0; i < row_len && left > 0; i++) begin
        pending_cells.push_back(random_cell(i == 0 || $urandom_range(0, 40) == 0));
        left--;
      end
    end
  endtask

  // Wait until the block has drained every request and settled.
  task automatic drain();
    wait (pending_cells.size() == 0 && !in_ch.valid && expected_faces.size() == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [EpsW-1:0] value);
    drain();
    eps_writes.push_back(value);
    wait (eps_writes.size() == 0 && !cfg_ch.valid);
    @(posedge clk);
  endtask

  // Cell driver: advance the next request once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
      have_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cell_t c;
        c = cell_t'(in_ch.data);
        if (!c.row_start && have_left)
          expected_faces.push_back(predict_face(left_cell, c, eps_now));
        left_cell = c;
        have_left = 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cell_gap == 0 && pending_cells.size() > 0) begin
          in_ch.data <= pending_cells.pop_front();
          in_ch.valid <= 1;
          if ($urandom_range(0, 60) == 0) burst_mode = !burst_mode;
          cell_gap = burst_mode ? 0 : $urandom_range(0, 16);
        end else begin
          in_ch.valid <= 0;
          if (cell_gap > 0) cell_gap--;
        end
      end
    end
  end

  // Register writer: one request at a time, track the live epsilon.
  always @(posedge clk) begin
    if (rst) begin
      cfg_ch.valid <= 0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      eps_now = cfg_ch.data;
      cfg_ch.valid <= 0;
    end else if (!cfg_ch.valid && eps_writes.size() > 0) begin
      cfg_ch.data <= eps_writes.pop_front();
      cfg_ch.valid <= 1;
    end
  end

  // Face monitor: check against the oldest prediction, draw the next stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
      out_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        face_t got, want;
        got = face_t'(out_ch.data);
        if (expected_faces.size() == 0) begin
          $display("%0t: face with none predicted, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_faces.pop_front();
          if (got.mass !== want.mass) begin
            $display("%0t: mass expected %h actual %h", $time, want.mass, got.mass);
            errors++;
          end
          if (got.mom !== want.mom) begin
            $display("%0t: momentum expected %h actual %h", $time, want.mom, got.mom);
            errors++;
          end
          if (got.energy !== want.energy) begin
            $display("%0t: energy expected %h actual %h", $time, want.energy, got.energy);
            errors++;
          end
        end
        out_wait = burst_mode ? 0 : $urandom_range(0, 16);
      end
      if (stall_served != stall_asked) begin
        // Long back-pressure: hold off so the block fills and stalls its input.
        out_wait = LongHold;
        stall_served = stall_asked;
      end
      if (out_wait > 0) begin
        out_ch.ready <= 0;
        out_wait--;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Directed: no previous cell after reset, identical cells (zero
    // difference, alpha falls to the lower wave-speed bound), field extremes.
    pending_cells.push_back(make_cell(0, 31'd65536, 32'sd65536, 31'd65536, 31'd65536,
                                      32'sd65536, 31'd65536));
    pending_cells.push_back(make_cell(0, 31'd65536, 32'sd65536, 31'd65536, 31'd65536,
                                      32'sd65536, 31'd65536));
    pending_cells.push_back(make_cell(0, 31'h7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF,
                                      31'h7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF));
    pending_cells.push_back(make_cell(0, 31'd0, 32'sh80000000, 31'd0, 31'd0,
                                      32'sh80000000, 31'd0));
    pending_cells.push_back(make_cell(0, 31'h7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF,
                                      31'h7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF));
    pending_cells.push_back(make_cell(1, 31'd131072, 32'sd0, 31'd70000, 31'd65536,
                                      32'sd0, 31'd200000));
    // Zero velocity on both sides: tiny flux difference, alpha goes to zero.
    pending_cells.push_back(make_cell(0, 31'd262144, 32'sd0, 31'd70000, 31'd65536,
                                      32'sd5, 31'd300000));
    pending_cells.push_back(make_cell(0, 31'd262145, -32'sd98304, 31'd80000, 31'd99999,
                                      -32'sd7, 31'd300001));
    pending_cells.push_back(make_cell(1, 31'd0, 32'sd0, 31'd0, 31'd0, 32'sd0, 31'd0));
    pending_cells.push_back(make_cell(0, 31'd0, 32'sd0, 31'd0, 31'd0, 32'sd0, 31'd0));
    for (int i = 0; i < 8; i++) pending_cells.push_back(random_cell(i == 0));
    queue_rows(150);

    // Zero epsilon: identical cells give a zero denominator, alpha takes the
    // upper wave-speed bound.
    write_epsilon(16'd0);
    pending_cells.push_back(make_cell(1, 31'd65536, 32'sd40000, 31'd90000, 31'd65536,
                                      32'sd3, 31'd100000));
    pending_cells.push_back(make_cell(0, 31'd65536, 32'sd40000, 31'd90000, 31'd65536,
                                      32'sd3, 31'd100000));
    queue_rows(170);
    stall_asked++;

    write_epsilon(16'hFFFF);
    queue_rows(170);

    write_epsilon(16'($urandom()));
    queue_rows(170);

    write_epsilon(16'd1);
    queue_rows(170);

    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
